@@ rtl/rsb_pkg.sv @@
`timescale 1ns / 1ps
// Package for the register scoreboard issue check: types, codes and constants.
// No dependencies; used by rsb_check and register_scoreboard_issue_check.
package rsb_pkg;

  localparam int RegCount = 32;
  localparam int RegIdxW  = 5;
  localparam int ImmW     = 20;
  localparam int InDataW  = 48;
  localparam int OutDataW = 8;

  localparam int BoxFirst = 3;
  localparam int BoxEnd   = 17;
  localparam int TriEnd   = 20;

  localparam logic [ImmW-1:0] ImmBox = ImmW'(1);
  localparam logic [ImmW-1:0] ImmTri = ImmW'(2);

  localparam logic ActIssue     = 1'b0;
  localparam logic ActWriteback = 1'b1;

  localparam logic FileInt   = 1'b0;
  localparam logic FileFloat = 1'b1;

  typedef enum logic [2:0] {
    FMT_R   = 3'd0,
    FMT_R4  = 3'd1,
    FMT_I   = 3'd2,
    FMT_S   = 3'd3,
    FMT_B   = 3'd4,
    FMT_U   = 3'd5,
    FMT_J   = 3'd6,
    FMT_UNK = 3'd7
  } fmt_t;

  typedef logic [RegCount-1:0] valid_vec_t;

  typedef struct packed {
    logic               action;
    fmt_t               format;
    logic               dest_file;
    logic               source_file;
    logic [RegIdxW-1:0] dest_reg;
    logic [RegIdxW-1:0] src_one;
    logic [RegIdxW-1:0] src_two;
    logic [RegIdxW-1:0] src_three;
    logic               is_custom;
    logic [ImmW-1:0]    custom_imm;
  } req_t;

  typedef struct packed {
    logic       issued;
    valid_vec_t int_valid;
    valid_vec_t float_valid;
  } upd_t;

endpackage

@@ rtl/rsb_check.sv @@
`timescale 1ns / 1ps
// Operand check and scoreboard next-state logic for one request.
// Depends on rsb_pkg.
module rsb_check (
  input  rsb_pkg::req_t      req,
  input  rsb_pkg::valid_vec_t int_valid,
  input  rsb_pkg::valid_vec_t float_valid,
  output rsb_pkg::upd_t      upd
);
  import rsb_pkg::*;

  valid_vec_t dst_bits;
  valid_vec_t src_bits;
  logic       dst_rd;
  logic       dst_rs2;
  logic       src_rs1;
  logic       src_rs2;
  logic       src_rs3;
  logic       box_ok;
  logic       tri_ok;
  logic       ok;
  logic       writes;
  valid_vec_t rd_mask;

  assign dst_bits = (req.dest_file == FileFloat) ? float_valid : int_valid;
  assign src_bits = (req.source_file == FileFloat) ? float_valid : int_valid;
  assign dst_rd   = dst_bits[req.dest_reg];
  assign dst_rs2  = dst_bits[req.src_two];
  assign src_rs1  = src_bits[req.src_one];
  assign src_rs2  = src_bits[req.src_two];
  assign src_rs3  = src_bits[req.src_three];
  assign box_ok   = &float_valid[BoxEnd-1:BoxFirst];
  assign tri_ok   = &float_valid[TriEnd-1:0];
  assign rd_mask  = valid_vec_t'(1) << req.dest_reg;

  always_comb begin
    ok     = 1'b0;
    writes = 1'b0;
    case (req.format)
      FMT_R: begin
        ok     = dst_rd & src_rs1 & src_rs2;
        writes = 1'b1;
      end
      FMT_R4: begin
        ok     = dst_rd & src_rs1 & src_rs2 & src_rs3;
        writes = 1'b1;
      end
      FMT_I: begin
        ok     = dst_rd & src_rs1;
        writes = 1'b1;
      end
      FMT_S: ok = dst_rs2 & src_rs1;
      FMT_B: ok = src_rs1 & src_rs2;
      FMT_U: begin
        ok = dst_rd;
        if (req.is_custom && req.custom_imm == ImmBox) begin
          ok = dst_rd & box_ok;
        end else if (req.is_custom && req.custom_imm == ImmTri) begin
          ok = dst_rd & tri_ok;
        end
        writes = 1'b1;
      end
      FMT_J: begin
        ok     = dst_rd;
        writes = 1'b1;
      end
      default: ok = 1'b0;
    endcase
  end

  always_comb begin
    upd.issued      = 1'b0;
    upd.int_valid   = int_valid;
    upd.float_valid = float_valid;
    if (req.action == ActWriteback) begin
      if (req.dest_file == FileFloat) begin
        upd.float_valid = float_valid | rd_mask;
      end else begin
        upd.int_valid = int_valid | rd_mask;
      end
    end else begin
      upd.issued = ok;
      if (ok && writes) begin
        if (req.dest_file == FileFloat) begin
          upd.float_valid = float_valid & ~rd_mask;
        end else begin
          upd.int_valid = int_valid & ~rd_mask;
        end
        // integer x0 is never pending
        upd.int_valid[0] = 1'b1;
      end
    end
  end

endmodule

@@ rtl/register_scoreboard_issue_check.sv @@
`timescale 1ns / 1ps
// Register scoreboard issue check, top level. Depends on rsb_pkg, rsb_check.
// Result valid in the cycle after acceptance. Throughput: one request per
// cycle unless the output stalls; the scoreboard is read and updated in the
// accepting cycle, so back-to-back requests see each other's effect.
// Reset (rst_n low, synchronous): all integer and float registers valid,
// output register empty.
module register_scoreboard_issue_check (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  // format[2:0], dest_file[3], source_file[4], dest_reg[9:5], src_one[14:10],
  // src_two[19:15], src_three[24:20], is_custom[25], custom_imm[45:26], zeros
  input  logic [rsb_pkg::InDataW-1:0]   in_tdata,
  // action[0]
  input  logic                          in_tuser,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // issued[0], zeros
  output logic [rsb_pkg::OutDataW-1:0]  out_tdata
);
  import rsb_pkg::*;

  req_t       req;
  upd_t       upd;
  logic       accept;
  valid_vec_t int_valid_r;
  valid_vec_t int_valid_nxt;
  valid_vec_t float_valid_r;
  valid_vec_t float_valid_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic       issued_r;
  logic       issued_nxt;

  assign req.action      = in_tuser;
  assign req.format      = fmt_t'(in_tdata[2:0]);
  assign req.dest_file   = in_tdata[3];
  assign req.source_file = in_tdata[4];
  assign req.dest_reg    = in_tdata[9:5];
  assign req.src_one     = in_tdata[14:10];
  assign req.src_two     = in_tdata[19:15];
  assign req.src_three   = in_tdata[24:20];
  assign req.is_custom   = in_tdata[25];
  assign req.custom_imm  = in_tdata[45:26];

  rsb_check u_check (
    .req         (req),
    .int_valid   (int_valid_r),
    .float_valid (float_valid_r),
    .upd         (upd)
  );

  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    int_valid_nxt   = int_valid_r;
    float_valid_nxt = float_valid_r;
    issued_nxt      = issued_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    if (accept) begin
      int_valid_nxt   = upd.int_valid;
      float_valid_nxt = upd.float_valid;
      issued_nxt      = upd.issued;
      out_valid_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      int_valid_r   <= '1;
      float_valid_r <= '1;
      out_valid_r   <= 1'b0;
    end else begin
      int_valid_r   <= int_valid_nxt;
      float_valid_r <= float_valid_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    issued_r <= issued_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OutDataW-1)'(0), issued_r};

endmodule

@@ rtl/rsb_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks for register_scoreboard_issue_check, with bind.
// Depends on rsb_pkg.
module rsb_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_tvalid,
  input logic                         in_tready,
  input logic [rsb_pkg::InDataW-1:0]  in_tdata,
  input logic                         in_tuser,
  input logic                         out_tvalid,
  input logic                         out_tready,
  input logic [rsb_pkg::OutDataW-1:0] out_tdata
);
  import rsb_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result changed");

  a_writeback_zero: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ActWriteback
    |=> out_tvalid && out_tdata[0] == 1'b0)
    else $error("writeback request reported issued");

  a_unknown_fails: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == ActIssue && in_tdata[2:0] == FMT_UNK
    |=> out_tvalid && out_tdata[0] == 1'b0)
    else $error("unknown format issued");

endmodule

bind register_scoreboard_issue_check rsb_checker u_rsb_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
